FILE: hdl/fxalu_pkg.sv
package fxalu_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 8;
  localparam int unsigned WORD_WIDTH_DEF    = 32;
  localparam int unsigned FIELD_W           = 32;
  localparam int unsigned MODE_W            = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD      = 4'd0,
    MODE_SUB      = 4'd1,
    MODE_MUL      = 4'd2,
    MODE_DIV      = 4'd3,
    MODE_MIN      = 4'd4,
    MODE_MAX      = 4'd5,
    MODE_INC      = 4'd6,
    MODE_DEC      = 4'd7,
    MODE_TO_INT   = 4'd8,
    MODE_FROM_INT = 4'd9
  } mode_e;

  // Flags and mode that ride along the divider row.
  typedef struct packed {
    logic             valid;
    logic [MODE_W-1:0] mode;
    logic             neg;
    logic             a_neg;
    logic             b_zero;
    logic             lt;
    logic             eq;
    logic             gt;
  } ctl_t;

endpackage

FILE: hdl/fixed_point_alu_q24_8_core.sv
// Signed fixed-point ALU, raw words with FRACTION_BITS fraction bits.
// Input: raise start with mode_i, operand_a_i and operand_b_i; busy
// is always low, so a new item is taken every cycle.
// Output: done_o is high for one cycle with result_o, the compare flags
// a_less_o/a_equal_o/a_greater_o, saturated_o and divide_by_zero_o.
// Every mode takes the same path: one input register, one stage for the
// product and the simple modes, one stage that rounds the product and sets
// up the divider, a row of W+FRACTION_BITS+1 division cells (one quotient
// bit per cell, W = min(WORD_WIDTH,32)), then a saturation/output register.
// Non-divide modes compute their result at the front and ride the row.
// Throughput: one item per cycle. Results come out in input order.
// Reset clears all valid bits; items in flight are dropped.
// The receiver cannot stall; done_o is not held off.
module fixed_point_alu_q24_8_core #(
  parameter int unsigned FRACTION_BITS = fxalu_pkg::FRACTION_BITS_DEF,
  parameter int unsigned WORD_WIDTH    = fxalu_pkg::WORD_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  mode_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic        done_o,
  output logic signed [31:0] result_o,
  output logic        a_less_o,
  output logic        a_equal_o,
  output logic        a_greater_o,
  output logic        saturated_o,
  output logic        divide_by_zero_o
);

  localparam int unsigned W  = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
  localparam int unsigned F  = FRACTION_BITS;
  // numerator 2*|a|<<F, denominator 2*|b|, quotient fits NW bits
  localparam int unsigned NW = W + F + 1;
  localparam int unsigned DW = W + 1;
  localparam int unsigned PW = 2 * W;

  logic signed [W-1:0] a_s, b_s;
  assign a_s = operand_a_i[W-1:0];
  assign b_s = operand_b_i[W-1:0];

  localparam logic signed [W+1:0] WMAX = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] WMIN = {3'b111, {(W-1){1'b0}}};

  // Stage 0: register inputs.
  logic                v0_q;
  logic [3:0]          m0_q;
  logic signed [W-1:0] a0_q, b0_q;
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else v0_q <= start;
  end
  always_ff @(posedge clk_i) begin
    m0_q <= mode_i;
    a0_q <= a_s;
    b0_q <= b_s;
  end

  // Stage 1: simple modes, the magnitude product and divider operands.
  logic [W-1:0] amag, bmag;
  logic         neg1;
  logic signed [W+1:0] aw, bw, sum;
  logic signed [W+F+1:0] shl;
  logic [W+1:0]  res1;
  logic          sat1;
  assign amag = a0_q[W-1] ? W'(-a0_q) : W'(a0_q);
  assign bmag = b0_q[W-1] ? W'(-b0_q) : W'(b0_q);
  assign neg1 = a0_q[W-1] ^ b0_q[W-1];
  assign aw   = (W+2)'(a0_q);
  assign bw   = (W+2)'(b0_q);
  assign shl  = (W+F+2)'(a0_q) <<< F;

  always_comb begin
    sum  = '0;
    res1 = '0;
    sat1 = 1'b0;
    unique case (m0_q)
      fxalu_pkg::MODE_ADD: sum = aw + bw;
      fxalu_pkg::MODE_SUB: sum = aw - bw;
      fxalu_pkg::MODE_INC: sum = aw + (W+2)'(1);
      fxalu_pkg::MODE_DEC: sum = aw - (W+2)'(1);
      default: sum = '0;
    endcase
    unique case (m0_q)
      fxalu_pkg::MODE_ADD, fxalu_pkg::MODE_SUB,
      fxalu_pkg::MODE_INC, fxalu_pkg::MODE_DEC: begin
        if (sum > WMAX) begin res1 = WMAX; sat1 = 1'b1; end
        else if (sum < WMIN) begin res1 = WMIN; sat1 = 1'b1; end
        else res1 = sum;
      end
      fxalu_pkg::MODE_MIN: res1 = (a0_q < b0_q) ? aw : bw;
      fxalu_pkg::MODE_MAX: res1 = (a0_q > b0_q) ? aw : bw;
      fxalu_pkg::MODE_TO_INT: res1 = (W+2)'(a0_q >>> F);
      fxalu_pkg::MODE_FROM_INT: begin
        if (shl > (W+F+2)'(WMAX)) begin res1 = WMAX; sat1 = 1'b1; end
        else if (shl < (W+F+2)'(WMIN)) begin res1 = WMIN; sat1 = 1'b1; end
        else res1 = shl[W+1:0];
      end
      default: res1 = '0;
    endcase
  end

  fxalu_pkg::ctl_t c1_q;
  logic [PW-1:0]   p1_q;
  logic [NW-1:0]   n1_q;
  logic [DW-1:0]   d1_q;
  logic [W-1:0]    r1_q;
  logic            s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c1_q <= '0;
    else begin
      c1_q.valid  <= v0_q;
      c1_q.mode   <= m0_q;
      c1_q.neg    <= neg1;
      c1_q.a_neg  <= a0_q[W-1];
      c1_q.b_zero <= (b0_q == '0);
      c1_q.lt     <= a0_q < b0_q;
      c1_q.eq     <= a0_q == b0_q;
      c1_q.gt     <= a0_q > b0_q;
    end
  end
  always_ff @(posedge clk_i) begin
    p1_q <= PW'(amag) * PW'(bmag);
    n1_q <= NW'(amag) << (F + 1);
    d1_q <= {bmag, 1'b0};
    r1_q <= res1[W-1:0];
    s1_q <= sat1;
  end

  // Multiply rounding result computed here and carried in res lane.
  logic [PW:0]   prnd;
  logic [PW:0]   pq;
  logic [W-1:0]  mres;
  logic          msat;
  assign prnd = {1'b0, p1_q} + ((F > 0) ? ((PW+1)'(1) << (F > 0 ? F - 1 : 0)) : '0);
  assign pq   = prnd >> F;

  always_comb begin
    msat = 1'b0;
    mres = '0;
    if (!c1_q.neg) begin
      if (pq > (PW+1)'(WMAX[W-1:0])) begin msat = 1'b1; mres = WMAX[W-1:0]; end
      else mres = pq[W-1:0];
    end else begin
      if (pq > (PW+1)'({1'b1, {(W-1){1'b0}}})) begin
        msat = 1'b1; mres = WMIN[W-1:0];
      end else mres = W'(-pq[W-1:0]);
    end
  end

  fxalu_pkg::ctl_t c2_q;
  logic [NW-1:0]   n2_q;
  logic [DW-1:0]   d2_q;
  logic [W-1:0]    r2_q;
  logic            s2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c2_q <= '0;
    else c2_q <= c1_q;
  end
  always_ff @(posedge clk_i) begin
    n2_q <= n1_q + NW'(d1_q >> 1);
    d2_q <= d1_q;
    r2_q <= (c1_q.mode == fxalu_pkg::MODE_MUL) ? mres : r1_q;
    s2_q <= (c1_q.mode == fxalu_pkg::MODE_MUL) ? msat : s1_q;
  end

  // Division row: (2n + d) / (2d), one quotient bit per cell.
  fxalu_pkg::ctl_t ctl_w [NW+1];
  logic [NW-1:0]   num_w [NW+1];
  logic [DW-1:0]   den_w [NW+1];
  logic [DW:0]     rem_w [NW+1];
  logic [NW-1:0]   quo_w [NW+1];
  logic [W-1:0]    res_w [NW+1];
  logic            sat_w [NW+1];

  assign ctl_w[0] = c2_q;
  assign num_w[0] = n2_q;
  assign den_w[0] = d2_q;
  assign rem_w[0] = '0;
  assign quo_w[0] = '0;
  assign res_w[0] = r2_q;
  assign sat_w[0] = s2_q;

  for (genvar i = 0; i < NW; i++) begin : g_row
    fxalu_div_cell #(.NW(NW), .DW(DW), .RW(W)) u_cell (
      .clk_i (clk_i), .rst_ni(rst_ni),
      .ctl_i (ctl_w[i]),   .num_i(num_w[i]),   .den_i(den_w[i]),
      .rem_i (rem_w[i]),   .quo_i(quo_w[i]),   .res_i(res_w[i]),
      .sat_i (sat_w[i]),
      .ctl_o (ctl_w[i+1]), .num_o(num_w[i+1]), .den_o(den_w[i+1]),
      .rem_o (rem_w[i+1]), .quo_o(quo_w[i+1]), .res_o(res_w[i+1]),
      .sat_o (sat_w[i+1])
    );
  end

  // Output stage.
  fxalu_pkg::ctl_t ce;
  logic [NW-1:0]   qe;
  logic [W-1:0]    rf;
  logic            sf, dzf;
  assign ce = ctl_w[NW];
  assign qe = quo_w[NW];

  always_comb begin
    rf  = res_w[NW];
    sf  = sat_w[NW];
    dzf = 1'b0;
    if (ce.mode == fxalu_pkg::MODE_DIV) begin
      if (ce.b_zero) begin
        dzf = 1'b1; sf = 1'b1;
        rf  = ce.a_neg ? WMIN[W-1:0] : WMAX[W-1:0];
      end else if (!ce.neg) begin
        if (qe > NW'(WMAX[W-1:0])) begin sf = 1'b1; rf = WMAX[W-1:0]; end
        else begin sf = 1'b0; rf = qe[W-1:0]; end
      end else begin
        if (qe > NW'({1'b1, {(W-1){1'b0}}})) begin sf = 1'b1; rf = WMIN[W-1:0]; end
        else begin sf = 1'b0; rf = W'(-qe[W-1:0]); end
      end
    end
  end

  logic        dn_q;
  logic [31:0] res_q;
  logic        lt_q, eq_q, gt_q, sat_q, dz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dn_q <= 1'b0;
    else dn_q <= ce.valid;
  end
  always_ff @(posedge clk_i) begin
    res_q <= 32'(signed'(rf));
    lt_q  <= ce.lt;
    eq_q  <= ce.eq;
    gt_q  <= ce.gt;
    sat_q <= sf;
    dz_q  <= dzf;
  end

  assign done_o           = dn_q;
  assign result_o         = res_q;
  assign a_less_o         = lt_q;
  assign a_equal_o        = eq_q;
  assign a_greater_o      = gt_q;
  assign saturated_o      = sat_q;
  assign divide_by_zero_o = dz_q;

  a_onecmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot({a_less_o, a_equal_o, a_greater_o}))
    else $error("compare flags not one-hot");
  a_dzsat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && divide_by_zero_o) |-> saturated_o)
    else $error("divide by zero without saturation");
  a_dzeq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && divide_by_zero_o) |-> !a_equal_o || result_o[W-1] == 1'b0)
    else $error("zero divide sign wrong");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

endmodule

FILE: hdl/fxalu_div_cell.sv
// One restoring-division step: shift in a numerator bit, try subtract.
module fxalu_div_cell #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 33,
  parameter int unsigned RW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fxalu_pkg::ctl_t ctl_i,
  input  logic [NW-1:0]   num_i,
  input  logic [DW-1:0]   den_i,
  input  logic [DW:0]     rem_i,
  input  logic [NW-1:0]   quo_i,
  input  logic [RW-1:0]   res_i,
  input  logic            sat_i,
  output fxalu_pkg::ctl_t ctl_o,
  output logic [NW-1:0]   num_o,
  output logic [DW-1:0]   den_o,
  output logic [DW:0]     rem_o,
  output logic [NW-1:0]   quo_o,
  output logic [RW-1:0]   res_o,
  output logic            sat_o
);

  logic [DW+1:0] trial;
  logic [DW+1:0] diff;
  logic          fits;
  fxalu_pkg::ctl_t ctl_q;
  logic [NW-1:0]   num_q, quo_q;
  logic [DW-1:0]   den_q;
  logic [DW:0]     rem_q;
  logic [RW-1:0]   res_q;
  logic            sat_q;

  assign trial = {rem_i, num_i[NW-1]};
  assign diff  = trial - {2'b00, den_i};
  assign fits  = ~diff[DW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= {num_i[NW-2:0], 1'b0};
    den_q <= den_i;
    rem_q <= fits ? diff[DW:0] : trial[DW:0];
    quo_q <= {quo_i[NW-2:0], fits};
    res_q <= res_i;
    sat_q <= sat_i;
  end

  assign ctl_o = ctl_q;
  assign num_o = num_q;
  assign den_o = den_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

FILE: bench/fxalu_checker.sv
module fxalu_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [3:0]         mode_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  input  logic               done_i,
  input  logic signed [31:0] result_i,
  input  logic               a_less_i,
  input  logic               a_equal_i,
  input  logic               a_greater_i,
  input  logic               saturated_i,
  input  logic               divide_by_zero_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);

  localparam int unsigned FRAC = fxalu_pkg::FRACTION_BITS_DEF;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] result;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               sat;
    logic               dz;
  } alu_out_t;

  alu_out_t expected_q[$];

  function automatic longint clamp_word(longint v, ref logic sat);
    if (v > WMAX) begin
      sat = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      sat = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  function automatic longint signed_round(longint unsigned mag, logic neg);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic alu_out_t compute_alu(logic [3:0] mode, logic signed [31:0] ra,
                                           logic signed [31:0] rb);
    alu_out_t o;
    longint a, b, r;
    longint unsigned ma, mb, p, q;
    logic sat, dz;
    a = ra;
    b = rb;
    sat = 1'b0;
    dz = 1'b0;
    r = 0;
    ma = (a < 0) ? longint'(-a) : a;
    mb = (b < 0) ? longint'(-b) : b;
    case (mode)
      fxalu_pkg::MODE_ADD: r = clamp_word(a + b, sat);
      fxalu_pkg::MODE_SUB: r = clamp_word(a - b, sat);
      fxalu_pkg::MODE_MUL: begin
        p = ma * mb;
        q = (p + (64'd1 << (FRAC - 1))) >> FRAC;
        r = clamp_word(signed_round(q, (a < 0) != (b < 0)), sat);
      end
      fxalu_pkg::MODE_DIV: begin
        if (b == 0) begin
          dz = 1'b1;
          sat = 1'b1;
          r = (a < 0) ? WMIN : WMAX;
        end else begin
          // round half away from zero on magnitudes
          q = (2 * (ma << FRAC) + mb) / (2 * mb);
          r = clamp_word(signed_round(q, (a < 0) != (b < 0)), sat);
        end
      end
      fxalu_pkg::MODE_MIN: r = (a < b) ? a : b;
      fxalu_pkg::MODE_MAX: r = (a > b) ? a : b;
      fxalu_pkg::MODE_INC: r = clamp_word(a + 1, sat);
      fxalu_pkg::MODE_DEC: r = clamp_word(a - 1, sat);
      fxalu_pkg::MODE_TO_INT: r = a >>> FRAC;
      fxalu_pkg::MODE_FROM_INT: r = clamp_word(a * (64'sd1 << FRAC), sat);
      default: r = 0;
    endcase
    o.result = r[31:0];
    o.lt = a < b;
    o.eq = a == b;
    o.gt = a > b;
    o.sat = sat;
    o.dz = dz;
    return o;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    alu_out_t want, got;
    if (!rst_ni) begin
      expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (done_i) begin
        got = '{result_i, a_less_i, a_equal_i, a_greater_i, saturated_i, divide_by_zero_i};
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected result %h flags %b", result_i, got[4:0]);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want != got) begin
            if (fail_count_o < 10)
              $display("mismatch: result exp %h got %h, lt/eq/gt/sat/dz exp %b got %b",
                       want.result, got.result, want[4:0], got[4:0]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // push after the pop so a same-cycle result cannot match this item
      if (start_i && !busy_i)
        expected_q.push_back(compute_alu(mode_i, operand_a_i, operand_b_i));
    end
  end

endmodule

FILE: bench/tb.sv
module tb;

  localparam logic [3:0] MODE_SPARE_LO = 4'd10;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

  logic clk_i, rst_ni, start, busy, done_o;
  logic [3:0] mode_i;
  logic signed [31:0] operand_a_i, operand_b_i, result_o;
  logic a_less_o, a_equal_o, a_greater_o, saturated_o, divide_by_zero_o;
  int unsigned pending, fail_count;
  bit no_idle;

  fixed_point_alu_q24_8_core dut (.*);

  fxalu_checker chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .mode_i, .operand_a_i,
    .operand_b_i, .done_i(done_o), .result_i(result_o), .a_less_i(a_less_o),
    .a_equal_i(a_equal_o), .a_greater_i(a_greater_o), .saturated_i(saturated_o),
    .divide_by_zero_i(divide_by_zero_o), .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("fixed_point_alu_q24_8_core verification failed");
    $finish;
  end

  // hold start through busy, then leave it high only if another item follows
  task automatic issue_item(logic [3:0] mode, logic signed [31:0] a, logic signed [31:0] b);
    int gap;
    gap = 0;
    if (!no_idle) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = 0;
        6, 7, 8: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(10, 40);
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    mode_i <= mode;
    operand_a_i <= a;
    operand_b_i <= b;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 4095)) - 2048;
      3: case ($urandom_range(0, 4))
           0: return WORD_MAX;
           1: return WORD_MIN;
           2: return 0;
           3: return 1;
           default: return -1;
         endcase
      4: return ($signed($urandom_range(0, 255)) - 128) <<< 8;
      default: return $urandom >>> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    logic [3:0] mode;
    logic signed [31:0] a;
    rst_ni = 1'b0;
    start = 1'b0;
    mode_i = fxalu_pkg::MODE_ADD;
    operand_a_i = '0;
    operand_b_i = '0;
    no_idle = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    issue_item(fxalu_pkg::MODE_ADD, WORD_MAX, WORD_MAX);
    issue_item(fxalu_pkg::MODE_ADD, WORD_MIN, WORD_MIN);
    issue_item(fxalu_pkg::MODE_SUB, WORD_MIN, 1);
    issue_item(fxalu_pkg::MODE_SUB, WORD_MAX, WORD_MIN);
    issue_item(fxalu_pkg::MODE_MUL, 1, 128);           // tie rounds up
    issue_item(fxalu_pkg::MODE_MUL, -1, 128);          // tie rounds away from zero
    issue_item(fxalu_pkg::MODE_MUL, WORD_MAX, WORD_MIN);
    issue_item(fxalu_pkg::MODE_MUL, 32'sh00000180, 32'sh00000180);
    issue_item(fxalu_pkg::MODE_DIV, 5, 0);
    issue_item(fxalu_pkg::MODE_DIV, -5, 0);
    issue_item(fxalu_pkg::MODE_DIV, 0, 0);
    issue_item(fxalu_pkg::MODE_DIV, WORD_MIN, -1);
    issue_item(fxalu_pkg::MODE_DIV, 1, 512);           // exact half
    issue_item(fxalu_pkg::MODE_DIV, -1, 512);
    issue_item(fxalu_pkg::MODE_MIN, 7, 7);
    issue_item(fxalu_pkg::MODE_MAX, WORD_MIN, WORD_MAX);
    issue_item(fxalu_pkg::MODE_MIN, WORD_MIN, WORD_MAX);
    issue_item(fxalu_pkg::MODE_INC, WORD_MAX, 0);
    issue_item(fxalu_pkg::MODE_DEC, WORD_MIN, 0);
    issue_item(fxalu_pkg::MODE_TO_INT, -1, 3);
    issue_item(fxalu_pkg::MODE_TO_INT, WORD_MIN, 3);
    issue_item(fxalu_pkg::MODE_FROM_INT, 32'sh00800000, 0);
    issue_item(fxalu_pkg::MODE_FROM_INT, -32'sh00800001, 0);
    issue_item(MODE_SPARE_LO, 3, -3);
    issue_item(MODE_SPARE_HI, WORD_MIN, WORD_MIN);

    for (int n = 0; n < 1600; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 15) == 0)
        mode = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      else
        mode = 4'($urandom_range(fxalu_pkg::MODE_ADD, fxalu_pkg::MODE_FROM_INT));
      a = pick_word();
      issue_item(mode, a, ($urandom_range(0, 9) == 0) ? a : pick_word());
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0)
      $display("fixed_point_alu_q24_8_core verification clean");
    else
      $display("fixed_point_alu_q24_8_core verification failed");
    $finish;
  end

endmodule
